// ----- rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Types and constants shared by the two-axis sun tracker controller files.
// ----------------------------------------------------------------------------
package stc_pkg;

	typedef enum logic [2:0] {
		MD_NORMAL  = 3'd0,
		MD_STORM   = 3'd1,
		MD_MORNING = 3'd2,
		MD_NIGHT   = 3'd3,
		MD_MANUAL  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		AZ_STOP  = 2'd0,
		AZ_LEFT  = 2'd1,
		AZ_RIGHT = 2'd2
	} az_dir_t;

	typedef enum logic [1:0] {
		EL_STOP = 2'd0,
		EL_UP   = 2'd1,
		EL_DOWN = 2'd2
	} el_dir_t;

	// configuration register indexes
	localparam logic [2:0] REG_AZ_MIN    = 3'd0;
	localparam logic [2:0] REG_AZ_MAX    = 3'd1;
	localparam logic [2:0] REG_EL_MIN    = 3'd2;
	localparam logic [2:0] REG_EL_MAX    = 3'd3;
	localparam logic [2:0] REG_AZ_TOL    = 3'd4;
	localparam logic [2:0] REG_EL_TOL    = 3'd5;
	localparam logic [2:0] REG_STORM_AZ  = 3'd6;
	localparam logic [2:0] REG_STORM_EL  = 3'd7;

	// command bytes
	localparam logic [7:0] CMD_LEFT  = 8'h61; // a
	localparam logic [7:0] CMD_RIGHT = 8'h64; // d
	localparam logic [7:0] CMD_UP    = 8'h77; // w
	localparam logic [7:0] CMD_DOWN  = 8'h73; // s

	localparam logic [63:0] HOLD_MS = 64'd300000;
	localparam logic [63:0] STOP_MS = 64'd600;
	localparam logic [9:0] STORM_THRESHOLD = 10'd512;
	localparam logic signed [7:0] NIGHT_ELEVATION = -8'sd10;
	localparam logic [4:0] NOON_HOUR = 5'd12;
	localparam logic [8:0] MORNING_AZIMUTH = 9'd110;

	typedef struct packed {
		logic [31:0]       time_ms;
		logic [8:0]        sun_azimuth;
		logic signed [7:0] sun_elevation;
		logic [8:0]        plant_azimuth;
		logic signed [7:0] plant_elevation;
		logic [4:0]        hour_of_day;
		logic [9:0]        storm_level;
		logic              cmd_valid;
		logic [7:0]        cmd_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] azimuth_drive;
		logic [1:0] elevation_drive;
	} out_word_t;

endpackage

// ----- rtl/two_axis_sun_tracker_controller.sv -----
// ----------------------------------------------------------------------------
// two_axis_sun_tracker_controller
// Per-tick mode selection and two-axis drive control with manual jog override.
// ----------------------------------------------------------------------------
// Path: a word accepted into the input register is loaded into the result
// register once the output can take it, through a single pass between the two.
// Throughput: one word per cycle unless out_stall holds a waiting result; the
// tick logic between the input register and the result register is a single pass.
// Reset: clears drives, mode, command history, pending byte, valid flags and
// loads the configuration registers with their defaults.
module two_axis_sun_tracker_controller #(
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stc_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [8:0]         cfg_data
);
	import stc_pkg::*;

	// configuration
	logic [8:0]        az_min_q, az_max_q, storm_az_q;
	logic signed [7:0] el_min_q, el_max_q, storm_el_q;
	logic [6:0]        az_tol_q, el_tol_q;

	// tick state
	az_dir_t              az_dir_q, az_dir_d, az_lim;
	el_dir_t              el_dir_q, el_dir_d, el_lim;
	mode_t                mode_q, mode_d;
	logic [TIME_BITS-1:0] last_q, last_d;
	logic                 seen_q, seen_d;
	logic                 pend_v_q, pend_v_d;
	logic [7:0]           pend_b_q, pend_b_d;

	// pipeline
	in_word_t  in_s1;
	logic      valid_s1;
	out_word_t out_q;
	logic      out_valid_q;
	logic      out_load;

	// tick datapath
	logic [TIME_BITS-1:0] now, diff;
	logic                 after_last, manual, stop_late;
	logic [7:0]           cmd;
	logic [8:0]           t_az;
	logic signed [7:0]    t_el;
	mode_t                auto_mode;
	logic signed [8:0]    el_up_err, el_dn_err, el_tol_s;
	logic [9:0]           az_rt_err, az_lt_err;

	assign cfg_ready = 1'b1;
	assign out_load  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !out_load;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_min_q   <= 9'd60;
			az_max_q   <= 9'd300;
			el_min_q   <= 8'sd0;
			el_max_q   <= 8'sd80;
			az_tol_q   <= 7'd5;
			el_tol_q   <= 7'd5;
			storm_az_q <= 9'd180;
			storm_el_q <= 8'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AZ_MIN:   az_min_q   <= cfg_data;
				REG_AZ_MAX:   az_max_q   <= cfg_data;
				REG_EL_MIN:   el_min_q   <= cfg_data[7:0];
				REG_EL_MAX:   el_max_q   <= cfg_data[7:0];
				REG_AZ_TOL:   az_tol_q   <= cfg_data[6:0];
				REG_EL_TOL:   el_tol_q   <= cfg_data[6:0];
				REG_STORM_AZ: storm_az_q <= cfg_data;
				REG_STORM_EL: storm_el_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// window checks against the last command time, no wrap
	assign now        = TIME_BITS'(in_s1.time_ms);
	assign diff       = now - last_q;
	assign after_last = seen_q && (last_q <= now);
	assign manual     = after_last && (64'(diff) <= HOLD_MS);
	assign stop_late  = after_last && (64'(diff) > STOP_MS);
	assign cmd        = pend_v_q ? pend_b_q : in_s1.cmd_byte;

	// target selection
	always_comb begin
		if (in_s1.storm_level > STORM_THRESHOLD) begin
			auto_mode = MD_STORM;
			t_az      = storm_az_q;
			t_el      = storm_el_q;
		end else if (in_s1.sun_elevation < NIGHT_ELEVATION) begin
			if (in_s1.hour_of_day < NOON_HOUR) begin
				auto_mode = MD_MORNING;
				t_az      = MORNING_AZIMUTH;
				t_el      = el_min_q;
			end else begin
				auto_mode = MD_NIGHT;
				t_az      = in_s1.plant_azimuth;
				t_el      = in_s1.plant_elevation;
			end
		end else begin
			auto_mode = MD_NORMAL;
			t_az      = in_s1.sun_azimuth;
			t_el      = in_s1.sun_elevation;
		end
	end

	assign el_up_err = 9'(t_el) - 9'(in_s1.plant_elevation);
	assign el_dn_err = 9'(in_s1.plant_elevation) - 9'(t_el);
	assign el_tol_s  = $signed({2'b00, el_tol_q});
	assign az_rt_err = {1'b0, t_az} - {1'b0, in_s1.plant_azimuth};
	assign az_lt_err = {1'b0, in_s1.plant_azimuth} - {1'b0, t_az};

	// travel limits apply outside manual mode
	always_comb begin
		az_lim = az_dir_q;
		el_lim = el_dir_q;
		if (!manual) begin
			if (az_dir_q == AZ_RIGHT && in_s1.plant_azimuth >= az_max_q) az_lim = AZ_STOP;
			if (az_dir_q == AZ_LEFT && in_s1.plant_azimuth <= az_min_q) az_lim = AZ_STOP;
			if (el_dir_q == EL_UP && in_s1.plant_elevation >= el_max_q) el_lim = EL_STOP;
			if (el_dir_q == EL_DOWN && in_s1.plant_elevation <= el_min_q) el_lim = EL_STOP;
		end
	end

	always_comb begin
		az_dir_d = az_lim;
		el_dir_d = el_lim;
		mode_d   = mode_q;
		last_d   = last_q;
		seen_d   = seen_q;
		pend_v_d = pend_v_q;
		pend_b_d = pend_b_q;
		if (manual) begin
			mode_d = MD_MANUAL;
			if (pend_v_q || in_s1.cmd_valid) begin
				pend_v_d = 1'b0;
				last_d   = now;
				seen_d   = 1'b1;
				if (cmd == CMD_LEFT && az_lim != AZ_LEFT) begin
					el_dir_d = EL_STOP;
					az_dir_d = AZ_LEFT;
				end else if (cmd == CMD_RIGHT && az_lim != AZ_RIGHT) begin
					el_dir_d = EL_STOP;
					az_dir_d = AZ_RIGHT;
				end else if (cmd == CMD_UP && el_lim != EL_UP) begin
					az_dir_d = AZ_STOP;
					el_dir_d = EL_UP;
				end else if (cmd == CMD_DOWN && el_lim != EL_DOWN) begin
					az_dir_d = AZ_STOP;
					el_dir_d = EL_DOWN;
				end
			end else if (stop_late) begin
				az_dir_d = AZ_STOP;
				el_dir_d = EL_STOP;
			end
		end else if (pend_v_q || in_s1.cmd_valid) begin
			// byte only buffered; two bytes meeting here are both dropped
			last_d = now;
			seen_d = 1'b1;
			if (pend_v_q && in_s1.cmd_valid) begin
				pend_v_d = 1'b0;
			end else if (in_s1.cmd_valid) begin
				pend_v_d = 1'b1;
				pend_b_d = in_s1.cmd_byte;
			end
		end else begin
			mode_d = auto_mode;
			if (az_lim == AZ_STOP) begin
				if (in_s1.plant_elevation < t_el && el_lim != EL_DOWN) begin
					if (el_up_err > el_tol_s && t_el <= el_max_q) el_dir_d = EL_UP;
				end else if (in_s1.plant_elevation > t_el && el_lim != EL_UP) begin
					if (el_dn_err > el_tol_s && t_el >= el_min_q) el_dir_d = EL_DOWN;
				end else begin
					el_dir_d = EL_STOP;
				end
			end
			if (el_dir_d == EL_STOP) begin
				if (in_s1.plant_azimuth < t_az && az_lim != AZ_LEFT) begin
					if (az_rt_err > {3'b000, az_tol_q} && t_az <= az_max_q) az_dir_d = AZ_RIGHT;
				end else if (in_s1.plant_azimuth > t_az && az_lim != AZ_RIGHT) begin
					if (az_lt_err > {3'b000, az_tol_q} && t_az >= az_min_q) az_dir_d = AZ_LEFT;
				end else begin
					az_dir_d = AZ_STOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			az_dir_q    <= AZ_STOP;
			el_dir_q    <= EL_STOP;
			mode_q      <= MD_NORMAL;
			last_q      <= '0;
			seen_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_b_q    <= 8'd0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (out_load) begin
				out_valid_q <= 1'b1;
				az_dir_q    <= az_dir_d;
				el_dir_q    <= el_dir_d;
				mode_q      <= mode_d;
				last_q      <= last_d;
				seen_q      <= seen_d;
				pend_v_q    <= pend_v_d;
				pend_b_q    <= pend_b_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_s1 <= in_data;
		if (out_load) begin
			out_q.mode            <= mode_d;
			out_q.azimuth_drive   <= az_dir_d;
			out_q.elevation_drive <= el_dir_d;
		end
	end

endmodule

// ----- rtl/stc_checker.sv -----
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks for the sun tracker controller, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input stc_pkg::out_word_t out_data
);
	import stc_pkg::*;

	// held result word must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// after every accepted word a valid result word follows on the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("result missing two cycles after accept");

	// input only backs up when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// at most one axis moves at a time
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.azimuth_drive == AZ_STOP ||
			out_data.elevation_drive == EL_STOP))
		else $error("both axes driven");

	// mode code within the defined set
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.mode <= MD_MANUAL)
		else $error("undefined mode code");

endmodule

bind two_axis_sun_tracker_controller stc_checker u_stc_checker (.*);

// ----- sim/two_axis_sun_tracker_controller_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_sun_tracker_controller_test
// Self-checking bench for the sun tracker controller. A short table of ticks
// covers the modes, thresholds, field extremes and the manual command paths,
// then random ticks with a simple platform model follow under several limit
// settings. Both handshakes idle and stall at random; every result word is
// compared field by field against a known answer or a behavioral tracker model kept in the bench.
// ----------------------------------------------------------------------------
module two_axis_sun_tracker_controller_test;
	import stc_pkg::*;

	localparam int ITEMS_PER_PHASE = 225;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [7:0] NOT_A_JOG = 8'hFF;

	typedef struct {
		in_word_t  word;
		logic      known;
		out_word_t want;
	} tick_row_t;

	typedef struct {
		logic [8:0] az_min;
		logic [8:0] az_max;
		logic [8:0] el_min;
		logic [8:0] el_max;
		logic [8:0] az_tol;
		logic [8:0] el_tol;
		logic [8:0] storm_az;
		logic [8:0] storm_el;
	} limits_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	two_axis_sun_tracker_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tracker model: limit registers and controller state
	logic [8:0]        lim_az_min = 9'd60;
	logic [8:0]        lim_az_max = 9'd300;
	logic signed [7:0] lim_el_min = 8'sd0;
	logic signed [7:0] lim_el_max = 8'sd80;
	logic [6:0]        lim_az_tol = 7'd5;
	logic [6:0]        lim_el_tol = 7'd5;
	logic [8:0]        lim_storm_az = 9'd180;
	logic signed [7:0] lim_storm_el = 8'sd0;

	az_dir_t     az_dir = AZ_STOP;
	el_dir_t     el_dir = EL_STOP;
	mode_t       cur_mode = MD_NORMAL;
	logic [31:0] last_cmd_ms = '0;
	logic        cmd_seen = 1'b0;
	logic        held_valid = 1'b0;
	logic [7:0]  held_byte = '0;

	out_word_t drive_words[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	logic      calm_in = 1'b0;
	logic      calm_out = 1'b0;
	int        stall_wait = 0;

	// stimulus world: time base, sun and platform positions
	logic [31:0] clock_ms = '0;
	int          sun_az = 180;
	int          sun_el = 20;
	int          plant_az = 180;
	int          plant_el = 20;

	function automatic out_word_t track_tick(in_word_t w);
		logic [31:0] now;
		int          s_az, s_el, p_az, p_el, t_az, t_el;
		int          az_lo, az_hi, el_lo, el_hi, az_tol, el_tol;
		logic        manual;
		logic [7:0]  code;
		now = w.time_ms;
		s_az = w.sun_azimuth;
		s_el = $signed(w.sun_elevation);
		p_az = w.plant_azimuth;
		p_el = $signed(w.plant_elevation);
		az_lo = lim_az_min;
		az_hi = lim_az_max;
		el_lo = lim_el_min;
		el_hi = lim_el_max;
		az_tol = lim_az_tol;
		el_tol = lim_el_tol;
		manual = cmd_seen && last_cmd_ms <= now && (now - last_cmd_ms) <= HOLD_MS;

		if (!manual) begin
			if (az_dir == AZ_RIGHT && p_az >= az_hi) az_dir = AZ_STOP;
			if (az_dir == AZ_LEFT && p_az <= az_lo) az_dir = AZ_STOP;
			if (el_dir == EL_UP && p_el >= el_hi) el_dir = EL_STOP;
			if (el_dir == EL_DOWN && p_el <= el_lo) el_dir = EL_STOP;
		end

		if (manual) begin
			cur_mode = MD_MANUAL;
			if (held_valid || w.cmd_valid) begin
				// a held byte wins; a new byte arriving with it is dropped
				code = held_valid ? held_byte : w.cmd_byte;
				held_valid = 1'b0;
				if (code == CMD_LEFT && az_dir != AZ_LEFT) begin
					el_dir = EL_STOP;
					az_dir = AZ_LEFT;
				end else if (code == CMD_RIGHT && az_dir != AZ_RIGHT) begin
					el_dir = EL_STOP;
					az_dir = AZ_RIGHT;
				end else if (code == CMD_UP && el_dir != EL_UP) begin
					az_dir = AZ_STOP;
					el_dir = EL_UP;
				end else if (code == CMD_DOWN && el_dir != EL_DOWN) begin
					az_dir = AZ_STOP;
					el_dir = EL_DOWN;
				end
				last_cmd_ms = now;
				cmd_seen = 1'b1;
			end
			if (cmd_seen && last_cmd_ms <= now && (now - last_cmd_ms) > STOP_MS) begin
				az_dir = AZ_STOP;
				el_dir = EL_STOP;
			end
		end else if (held_valid || w.cmd_valid) begin
			// byte outside manual: hold it, or drop both if one is already held; mode output unchanged
			last_cmd_ms = now;
			cmd_seen = 1'b1;
			if (held_valid && w.cmd_valid) begin
				held_valid = 1'b0;
			end else if (w.cmd_valid) begin
				held_valid = 1'b1;
				held_byte = w.cmd_byte;
			end
		end else begin
			if (w.storm_level > STORM_THRESHOLD) begin
				cur_mode = MD_STORM;
				t_az = lim_storm_az;
				t_el = lim_storm_el;
			end else if (s_el < NIGHT_ELEVATION) begin
				if (w.hour_of_day < NOON_HOUR) begin
					cur_mode = MD_MORNING;
					t_az = MORNING_AZIMUTH;
					t_el = el_lo;
				end else begin
					cur_mode = MD_NIGHT;
					t_az = p_az;
					t_el = p_el;
				end
			end else begin
				cur_mode = MD_NORMAL;
				t_az = s_az;
				t_el = s_el;
			end

			// one axis at a time: elevation only while azimuth is idle
			if (az_dir == AZ_STOP) begin
				if (p_el < t_el && el_dir != EL_DOWN) begin
					if (t_el - p_el > el_tol && t_el <= el_hi) el_dir = EL_UP;
				end else if (p_el > t_el && el_dir != EL_UP) begin
					if (p_el - t_el > el_tol && t_el >= el_lo) el_dir = EL_DOWN;
				end else begin
					el_dir = EL_STOP;
				end
			end
			if (el_dir == EL_STOP) begin
				if (p_az < t_az && az_dir != AZ_LEFT) begin
					if (t_az - p_az > az_tol && t_az <= az_hi) az_dir = AZ_RIGHT;
				end else if (p_az > t_az && az_dir != AZ_RIGHT) begin
					if (p_az - t_az > az_tol && t_az >= az_lo) az_dir = AZ_LEFT;
				end else begin
					az_dir = AZ_STOP;
				end
			end
		end
		return out_word_t'{cur_mode, az_dir, el_dir};
	endfunction

	function automatic in_word_t tick_word(logic [31:0] t, int s_az, int s_el, int p_az,
			int p_el, int hour, int storm, logic cv, logic [7:0] cb);
		in_word_t w;
		w.time_ms = t;
		w.sun_azimuth = 9'(s_az);
		w.sun_elevation = 8'(s_el);
		w.plant_azimuth = 9'(p_az);
		w.plant_elevation = 8'(p_el);
		w.hour_of_day = 5'(hour);
		w.storm_level = 10'(storm);
		w.cmd_valid = cv;
		w.cmd_byte = cb;
		return w;
	endfunction

	function automatic logic [8:0] el_code(int deg);
		return {1'b0, 8'(deg)};
	endfunction

	task automatic write_reg(input logic [2:0] index, input logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (index)
			REG_AZ_MIN:   lim_az_min = data;
			REG_AZ_MAX:   lim_az_max = data;
			REG_EL_MIN:   lim_el_min = data[7:0];
			REG_EL_MAX:   lim_el_max = data[7:0];
			REG_AZ_TOL:   lim_az_tol = data[6:0];
			REG_EL_TOL:   lim_el_tol = data[6:0];
			REG_STORM_AZ: lim_storm_az = data;
			REG_STORM_EL: lim_storm_el = data[7:0];
			default: ;
		endcase
	endtask

	task automatic program_limits(input limits_t s);
		write_reg(REG_AZ_MIN, s.az_min);
		write_reg(REG_AZ_MAX, s.az_max);
		write_reg(REG_EL_MIN, s.el_min);
		write_reg(REG_EL_MAX, s.el_max);
		write_reg(REG_AZ_TOL, s.az_tol);
		write_reg(REG_EL_TOL, s.el_tol);
		write_reg(REG_STORM_AZ, s.storm_az);
		write_reg(REG_STORM_EL, s.storm_el);
		cfg_valid <= 1'b0;
	endtask

	task automatic feed_tick(input in_word_t w, input logic known, input out_word_t want);
		int        gap;
		out_word_t predicted;
		gap = calm_in ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = track_tick(w);
		drive_words.push_back(known ? want : predicted);
	endtask

	task automatic random_tick();
		in_word_t w;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) clock_ms += $urandom_range(0, 250);
		else if (pick < 70) clock_ms += $urandom_range(250, 1200);
		else if (pick < 78) clock_ms += $urandom_range(299000, 301500);
		else if (pick < 86) begin
			// land right on the stop and hold edges
			case ($urandom_range(0, 3))
				0: clock_ms = last_cmd_ms + 32'(STOP_MS);
				1: clock_ms = last_cmd_ms + 32'(STOP_MS) + 32'd1;
				2: clock_ms = last_cmd_ms + 32'(HOLD_MS);
				default: clock_ms = last_cmd_ms + 32'(HOLD_MS) + 32'd1;
			endcase
		end else if (pick < 91) clock_ms -= $urandom_range(1, 1000);
		else if (pick < 96) clock_ms = $urandom;
		else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);

		if ($urandom_range(0, 11) == 0) begin
			sun_az = $urandom_range(0, 359);
			sun_el = int'($urandom_range(0, 180)) - 90;
		end else begin
			sun_az = sun_az + int'($urandom_range(0, 2)) - 1;
			sun_el = sun_el + int'($urandom_range(0, 2)) - 1;
		end
		sun_az = (sun_az < 0) ? 0 : (sun_az > 359) ? 359 : sun_az;
		sun_el = (sun_el < -90) ? -90 : (sun_el > 90) ? 90 : sun_el;
		if ($urandom_range(0, 32) == 0) begin
			plant_az = $urandom_range(0, 359);
			plant_el = int'($urandom_range(0, 180)) - 90;
		end

		w = tick_word(clock_ms, sun_az, sun_el, plant_az, plant_el, 0, 0, 1'b0, '0);
		w.hour_of_day = ($urandom_range(0, 11) == 0) ? 5'($urandom_range(24, 31))
			: 5'($urandom_range(0, 23));
		pick = $urandom_range(0, 99);
		if (pick < 75) w.storm_level = 10'($urandom_range(0, 512));
		else if (pick < 90) w.storm_level = 10'($urandom_range(513, 1023));
		else w.storm_level = 10'($urandom_range(510, 515));
		w.cmd_valid = ($urandom_range(0, 99) < 18);
		case ($urandom_range(0, 4))
			0: w.cmd_byte = CMD_LEFT;
			1: w.cmd_byte = CMD_RIGHT;
			2: w.cmd_byte = CMD_UP;
			3: w.cmd_byte = CMD_DOWN;
			default: w.cmd_byte = 8'($urandom);
		endcase
		// occasional raw field values outside the physical ranges
		if ($urandom_range(0, 19) == 0) begin
			w.sun_azimuth = 9'($urandom);
			w.sun_elevation = 8'($urandom);
			w.plant_azimuth = 9'($urandom);
			w.plant_elevation = 8'($urandom);
		end
		feed_tick(w, 1'b0, '0);

		// platform follows the commanded drives
		if (az_dir == AZ_RIGHT) plant_az += $urandom_range(0, 3);
		else if (az_dir == AZ_LEFT) plant_az -= $urandom_range(0, 3);
		if (el_dir == EL_UP) plant_el += $urandom_range(0, 3);
		else if (el_dir == EL_DOWN) plant_el -= $urandom_range(0, 3);
		plant_az = (plant_az < 0) ? 0 : (plant_az > 359) ? 359 : plant_az;
		plant_el = (plant_el < -90) ? -90 : (plant_el > 90) ? 90 : plant_el;
	endtask

	// result side: random stall and compare
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_words.size() == 0) begin
					$error("result word with nothing expected: %p", out_data);
					mismatches++;
				end else begin
					want = drive_words.pop_front();
					if (out_data.mode !== want.mode) begin
						$error("mode: expected %0d, got %0d", want.mode, out_data.mode);
						mismatches++;
					end
					if (out_data.azimuth_drive !== want.azimuth_drive) begin
						$error("azimuth_drive: expected %0d, got %0d",
							want.azimuth_drive, out_data.azimuth_drive);
						mismatches++;
					end
					if (out_data.elevation_drive !== want.elevation_drive) begin
						$error("elevation_drive: expected %0d, got %0d",
							want.elevation_drive, out_data.elevation_drive);
						mismatches++;
					end
				end
				stall_wait = calm_out ? 0 : $urandom_range(0, 8);
				if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
			end else if (stall_wait > 0) begin
				stall_wait--;
			end
			out_stall <= (stall_wait != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		tick_row_t plan[$];
		limits_t   phase_limits[5];

		// known answers at reset limits first, then model-checked paths
		plan.push_back('{tick_word(0, 180, 30, 180, 30, 10, 0, 1'b0, '0), 1'b1,
			out_word_t'{MD_NORMAL, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(10, 180, 30, 180, 0, 10, 1023, 1'b0, '0), 1'b1,
			out_word_t'{MD_STORM, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(20, 200, 40, 200, 40, 10, 512, 1'b0, '0), 1'b1,
			out_word_t'{MD_NORMAL, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(30, 200, 40, 180, 0, 10, 513, 1'b0, '0), 1'b1,
			out_word_t'{MD_STORM, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(40, 90, -11, 110, 0, 11, 0, 1'b0, '0), 1'b1,
			out_word_t'{MD_MORNING, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(50, 90, -11, 77, -5, 12, 0, 1'b0, '0), 1'b1,
			out_word_t'{MD_NIGHT, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(60, 150, -10, 150, -10, 3, 0, 1'b0, '0), 1'b1,
			out_word_t'{MD_NORMAL, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(70, 0, -128, 511, 127, 31, 0, 1'b0, '0), 1'b1,
			out_word_t'{MD_NIGHT, AZ_STOP, EL_STOP}});
		plan.push_back('{tick_word(80, 200, 30, 100, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		plan.push_back('{tick_word(90, 200, 30, 300, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		plan.push_back('{tick_word(100, 511, 127, 0, -128, 0, 0, 1'b0, '0), 1'b0, '0});
		// manual entry: first byte is held, second one arrives with it and is dropped
		plan.push_back('{tick_word(1000, 180, 30, 180, 30, 10, 0, 1'b1, CMD_LEFT), 1'b0, '0});
		plan.push_back('{tick_word(1100, 180, 30, 180, 30, 10, 0, 1'b1, CMD_UP), 1'b0, '0});
		plan.push_back('{tick_word(1200, 180, 30, 180, 30, 10, 0, 1'b1, CMD_DOWN), 1'b0, '0});
		plan.push_back('{tick_word(1800, 180, 30, 180, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		plan.push_back('{tick_word(1801, 180, 30, 180, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		plan.push_back('{tick_word(1900, 180, 30, 180, 30, 10, 0, 1'b1, CMD_RIGHT), 1'b0, '0});
		plan.push_back('{tick_word(2000, 180, 30, 180, 30, 10, 0, 1'b1, NOT_A_JOG), 1'b0, '0});
		plan.push_back('{tick_word(302000, 180, 30, 180, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		plan.push_back('{tick_word(302001, 200, 30, 200, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		// held byte meets a new one inside the manual window: the held byte wins, the new one is dropped
		plan.push_back('{tick_word(302100, 200, 30, 200, 30, 10, 0, 1'b1, CMD_DOWN), 1'b0, '0});
		plan.push_back('{tick_word(302200, 200, 30, 200, 30, 10, 0, 1'b1, CMD_LEFT), 1'b0, '0});
		plan.push_back('{tick_word(302300, 200, 30, 200, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		// time going backwards and wrapping ends the manual window
		plan.push_back('{tick_word(5, 250, 50, 200, 30, 10, 0, 1'b0, '0), 1'b0, '0});
		plan.push_back('{tick_word(32'hFFFF_FFFF, 250, 50, 200, 30, 10, 0, 1'b1, CMD_RIGHT),
			1'b0, '0});
		plan.push_back('{tick_word(0, 250, 50, 200, 30, 10, 0, 1'b0, '0), 1'b0, '0});

		phase_limits[0] = '{9'd0, 9'd359, el_code(-90), el_code(90), 9'd0, 9'd0, 9'd0,
			el_code(-90)};
		phase_limits[1] = '{9'd359, 9'd0, el_code(90), el_code(-90), 9'd90, 9'd127, 9'd359,
			el_code(90)};
		phase_limits[2] = '{9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
			9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom)};
		phase_limits[3] = '{9'd60, 9'd300, el_code(0), el_code(80), 9'd5, 9'd5, 9'd180,
			el_code(0)};
		phase_limits[4] = '{9'($urandom_range(0, 180)), 9'($urandom_range(180, 359)),
			el_code(-int'($urandom_range(0, 90))), el_code($urandom_range(0, 90)),
			9'($urandom_range(0, 20)), 9'($urandom_range(0, 20)),
			9'($urandom_range(0, 359)), el_code(int'($urandom_range(0, 180)) - 90)};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) feed_tick(plan[i].word, plan[i].known, plan[i].want);
		repeat (ITEMS_PER_PHASE) random_tick();

		for (int p = 0; p < 5; p++) begin
			in_valid <= 1'b0;
			while (drive_words.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			program_limits(phase_limits[p]);
			repeat (ITEMS_PER_PHASE) random_tick();
		end

		in_valid <= 1'b0;
		while (drive_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
